FILE: design/psd_pkg.sv
package psd_pkg;

	localparam int CNT_W = 32;
	localparam int SUM_W = 64;
	localparam int ID_W  = 64;
	localparam int TS_W  = 63;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	localparam logic [1:0] CFG_MIN_SAMPLES = 2'd0;
	localparam logic [1:0] CFG_AHEAD_PCT   = 2'd1;
	localparam logic [1:0] CFG_MIN_OFFSET  = 2'd2;

	localparam logic [15:0] MIN_SAMPLES_RST = 16'd16;
	localparam logic [6:0]  AHEAD_PCT_RST   = 7'd90;
	localparam logic [39:0] MIN_OFFSET_RST  = 40'd1000;
	localparam logic [6:0]  PCT_FULL        = 7'd100;

	typedef struct packed {
		logic load;
		logic idx_clr;
		logic idx_inc;
		logic rd;
		logic alloc;
		logic hit;
		logic upd;
		logic div_mod;
		logic div_mean;
		logic scan_clr;
		logic scan_take;
		logic scan_end;
		logic set_zero;
		logic set_full;
		logic set_sat;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic at_end;
		logic full;
		logic key_hit;
		logic sat;
		logic div_done;
		logic rem_zero;
		logic qual;
		logic better;
		logic out_free;
	} sts_t;

endpackage

FILE: design/psd_if.sv
interface psd_in_if;
	import psd_pkg::*;
	logic             valid;
	logic             ready;
	logic [ID_W-1:0]  source_id;
	logic [TS_W-1:0]  send_time;
	logic [TS_W-1:0]  receive_time;
	modport source (output valid, source_id, send_time, receive_time, input ready);
	modport sink (input valid, source_id, send_time, receive_time, output ready);
endinterface

interface psd_out_if;
	import psd_pkg::*;
	logic             valid;
	logic             ready;
	logic [1:0]       status;
	logic             evaluated;
	logic             has_skew;
	logic [ID_W-1:0]  skew_source;
	logic [TS_W-1:0]  skew_offset;
	modport source (output valid, status, evaluated, has_skew, skew_source, skew_offset,
		input ready);
	modport sink (input valid, status, evaluated, has_skew, skew_source, skew_offset,
		output ready);
endinterface

FILE: design/per_source_clock_skew_detector.sv
// An item with a zero time goes straight to its result; otherwise the lookup
// reads each stored source in turn, followed by the count check.
// A scan reads each stored source again and divides for each source that
// needs its mean, on the one shared bit-serial divider.
// One item at a time; the next item is taken once the result is registered.
// Reset empties the source table, clears the report and loads default settings.
module per_source_clock_skew_detector
	import psd_pkg::*;
#(
	parameter int SOURCES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	psd_in_if.sink       in_ch,
	psd_out_if.source    out_ch,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [39:0]  cfg_data
);
	cmd_t cmd;
	sts_t sts;

	psd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psd_dp #(.SOURCES(SOURCES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

endmodule

FILE: design/psd_div.sv
module psd_div
	import psd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [CNT_W-1:0]  divisor,
	output logic              done,
	output logic [SUM_W-1:0]  quot,
	output logic [CNT_W-1:0]  rem
);
	logic [SUM_W-1:0] q_q;
	logic [CNT_W-1:0] r_q;
	logic [CNT_W-1:0] d_q;
	logic [5:0]       step_q;
	logic             busy_q;
	logic             done_q;
	logic [CNT_W:0]   sh;
	logic             ge;

	// restoring division, one quotient bit per cycle
	assign sh = {r_q, q_q[SUM_W-1]};
	assign ge = sh >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 6'd1;
			if (step_q == 6'd63) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[SUM_W-2:0], ge};
			r_q <= ge ? CNT_W'(sh - {1'b0, d_q}) : sh[CNT_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

FILE: design/psd_dp.sv
module psd_dp
	import psd_pkg::*;
#(
	parameter int SOURCES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cmd_t         cmd,
	output sts_t         sts,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_idx,
	input  logic [39:0]  cfg_data,
	psd_in_if.sink       in_ch,
	psd_out_if.source    out_ch
);
	localparam int SW = $clog2(SOURCES + 1);
	localparam int IW = (SOURCES > 1) ? $clog2(SOURCES) : 1;

	logic [15:0] min_samples_q;
	logic [6:0]  ahead_pct_q;
	logic [39:0] min_offset_q;

	logic [ID_W-1:0]  id_q;
	logic [SUM_W-1:0] off_q;
	logic             zero_q;
	logic             new_q;
	logic [SW-1:0]    fill_q;
	logic [SW-1:0]    idx_q;
	logic [IW-1:0]    slot_q;
	logic [1:0]       status_q;
	logic             eval_q;

	logic [ID_W-1:0]  key_mem [SOURCES];
	logic [CNT_W-1:0] cnt_mem [SOURCES];
	logic [SUM_W-1:0] sum_mem [SOURCES];
	logic [CNT_W-1:0] ahd_mem [SOURCES];
	logic [ID_W-1:0]  rd_key_q;
	logic [CNT_W-1:0] rd_cnt_q;
	logic [SUM_W-1:0] rd_sum_q;
	logic [CNT_W-1:0] rd_ahd_q;

	logic             have_q;
	logic [TS_W-1:0]  best_q;
	logic [ID_W-1:0]  best_id_q;
	logic             found_q;
	logic [ID_W-1:0]  rep_src_q;
	logic [TS_W-1:0]  rep_off_q;

	logic             res_valid_q;
	logic [1:0]       res_status_q;
	logic             res_eval_q;
	logic             res_skew_q;
	logic [ID_W-1:0]  res_src_q;
	logic [TS_W-1:0]  res_off_q;

	logic [CNT_W-1:0] cur_cnt, cur_ahd, cnt_new, ahd_new;
	logic [SUM_W-1:0] cur_sum, sum_new;
	logic [SUM_W:0]   sum_x;
	logic [15:0]      need;
	logic [38:0]      ahd_x100, cnt_xpct;
	logic             div_done;
	logic [SUM_W-1:0] quot;
	logic [CNT_W-1:0] rem;
	logic [IW-1:0]    ridx;

	assign ridx = idx_q[IW-1:0];
	assign need = (min_samples_q == 16'd0) ? 16'd1 : min_samples_q;

	assign cur_cnt = new_q ? '0 : rd_cnt_q;
	assign cur_sum = new_q ? '0 : rd_sum_q;
	assign cur_ahd = new_q ? '0 : rd_ahd_q;
	assign cnt_new = cur_cnt + 32'd1;
	assign ahd_new = cur_ahd + CNT_W'(!off_q[SUM_W-1] && off_q != '0);

	// signed add with saturation at the 64-bit limits
	assign sum_x = {cur_sum[SUM_W-1], cur_sum} + {off_q[SUM_W-1], off_q};
	always_comb begin
		if (sum_x[SUM_W] != sum_x[SUM_W-1])
			sum_new = sum_x[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		else
			sum_new = sum_x[SUM_W-1:0];
	end

	assign ahd_x100 = 39'(rd_ahd_q) * 39'(PCT_FULL);
	assign cnt_xpct = 39'(rd_cnt_q) * 39'(ahead_pct_q);

	psd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_mod | cmd.div_mean),
		.dividend (cmd.div_mean ? rd_sum_q : {32'd0, cnt_new}),
		.divisor  (cmd.div_mean ? rd_cnt_q : {16'd0, need}),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	always_comb begin
		sts.zero     = zero_q;
		sts.at_end   = idx_q == fill_q;
		sts.full     = fill_q == SW'(SOURCES);
		sts.key_hit  = rd_key_q == id_q;
		sts.sat      = cur_cnt == '1;
		sts.div_done = div_done;
		sts.rem_zero = rem == '0;
		// mean can be positive only for a positive sum
		sts.qual     = rd_cnt_q >= {16'd0, need} && ahd_x100 >= cnt_xpct &&
			!rd_sum_q[SUM_W-1] && rd_sum_q != '0;
		sts.better   = quot != '0 && quot >= {24'd0, min_offset_q} &&
			(!have_q || quot > {1'b0, best_q} ||
			(quot == {1'b0, best_q} && rd_key_q < best_id_q));
		sts.out_free = !res_valid_q || out_ch.ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_samples_q <= MIN_SAMPLES_RST;
			ahead_pct_q   <= AHEAD_PCT_RST;
			min_offset_q  <= MIN_OFFSET_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_MIN_SAMPLES: min_samples_q <= cfg_data[15:0];
				CFG_AHEAD_PCT:   ahead_pct_q   <= cfg_data[6:0];
				CFG_MIN_OFFSET:  min_offset_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q   <= in_ch.source_id;
			off_q  <= {1'b0, in_ch.send_time} - {1'b0, in_ch.receive_time};
			zero_q <= in_ch.send_time == '0 || in_ch.receive_time == '0;
		end
		if (cmd.rd) begin
			rd_key_q <= key_mem[ridx];
			rd_cnt_q <= cnt_mem[ridx];
			rd_sum_q <= sum_mem[ridx];
			rd_ahd_q <= ahd_mem[ridx];
		end
		if (cmd.upd) begin
			key_mem[slot_q] <= id_q;
			cnt_mem[slot_q] <= cnt_new;
			sum_mem[slot_q] <= sum_new;
			ahd_mem[slot_q] <= ahd_new;
		end
		if (cmd.alloc)
			slot_q <= fill_q[IW-1:0];
		else if (cmd.hit)
			slot_q <= ridx;
		if (cmd.load)
			new_q <= 1'b0;
		else if (cmd.alloc)
			new_q <= 1'b1;
		if (cmd.scan_take) begin
			best_q    <= quot[TS_W-1:0];
			best_id_q <= rd_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			idx_q    <= '0;
			status_q <= ST_OK;
			eval_q   <= 1'b0;
			have_q   <= 1'b0;
			found_q  <= 1'b0;
			rep_src_q <= '0;
			rep_off_q <= '0;
		end else begin
			if (cmd.alloc)
				fill_q <= fill_q + SW'(1);
			if (cmd.idx_clr)
				idx_q <= '0;
			else if (cmd.idx_inc)
				idx_q <= idx_q + SW'(1);
			priority if (cmd.set_zero)
				status_q <= ST_ZERO;
			else if (cmd.set_full)
				status_q <= ST_FULL;
			else if (cmd.set_sat)
				status_q <= ST_SAT;
			else if (cmd.upd)
				status_q <= ST_OK;
			if (cmd.load)
				eval_q <= 1'b0;
			else if (cmd.scan_clr)
				eval_q <= 1'b1;
			if (cmd.scan_clr)
				have_q <= 1'b0;
			else if (cmd.scan_take)
				have_q <= 1'b1;
			if (cmd.scan_end) begin
				found_q <= have_q;
				if (have_q) begin
					rep_src_q <= best_id_q;
					rep_off_q <= best_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.out_load)
			res_valid_q <= 1'b1;
		else if (out_ch.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_status_q <= status_q;
			res_eval_q   <= eval_q;
			res_skew_q   <= found_q;
			res_src_q    <= rep_src_q;
			res_off_q    <= rep_off_q;
		end
	end

	assign out_ch.valid       = res_valid_q;
	assign out_ch.status      = res_status_q;
	assign out_ch.evaluated   = res_eval_q;
	assign out_ch.has_skew    = res_skew_q;
	assign out_ch.skew_source = res_src_q;
	assign out_ch.skew_offset = res_off_q;

`ifndef SYNTH
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= SW'(SOURCES))
		else $error("table fill beyond size");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= fill_q)
		else $error("walk index past fill");
	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |=> fill_q == $past(fill_q) + SW'(1))
		else $error("allocation did not grow table");
	a_no_full_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !sts.full)
		else $error("allocation into full table");
`endif

endmodule

FILE: design/psd_ctrl.sv
module psd_ctrl
	import psd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  sts_t  sts,
	output cmd_t  cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_CHK   = 4'd1;
	localparam logic [3:0] S_LOOK  = 4'd2;
	localparam logic [3:0] S_LOOKW = 4'd3;
	localparam logic [3:0] S_ALLOC = 4'd4;
	localparam logic [3:0] S_UPD   = 4'd5;
	localparam logic [3:0] S_MODW  = 4'd6;
	localparam logic [3:0] S_SRD   = 4'd7;
	localparam logic [3:0] S_SCHK  = 4'd8;
	localparam logic [3:0] S_SDIV  = 4'd9;
	localparam logic [3:0] S_DONE  = 4'd10;

	logic [3:0] state_q, state_d;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.idx_clr = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.zero) begin
					cmd.set_zero = 1'b1;
					state_d      = S_DONE;
				end else begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.at_end) begin
					state_d = S_ALLOC;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_LOOKW;
				end
			end
			S_LOOKW: begin
				if (sts.key_hit) begin
					cmd.hit = 1'b1;
					state_d = S_UPD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_LOOK;
				end
			end
			S_ALLOC: begin
				if (sts.full) begin
					cmd.set_full = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.alloc = 1'b1;
					state_d   = S_UPD;
				end
			end
			S_UPD: begin
				if (sts.sat) begin
					cmd.set_sat = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.upd     = 1'b1;
					cmd.div_mod = 1'b1;
					state_d     = S_MODW;
				end
			end
			S_MODW: begin
				if (sts.div_done) begin
					if (sts.rem_zero) begin
						cmd.scan_clr = 1'b1;
						cmd.idx_clr  = 1'b1;
						state_d      = S_SRD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SRD: begin
				if (sts.at_end) begin
					cmd.scan_end = 1'b1;
					state_d      = S_DONE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = S_SCHK;
				end
			end
			S_SCHK: begin
				if (sts.qual) begin
					cmd.div_mean = 1'b1;
					state_d      = S_SDIV;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SRD;
				end
			end
			S_SDIV: begin
				if (sts.div_done) begin
					cmd.scan_take = sts.better;
					cmd.idx_inc   = 1'b1;
					state_d       = S_SRD;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

`ifndef SYNTH
	a_wait_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_mod || cmd.div_mean) |=> !sts.div_done)
		else $error("divider done right after start");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.upd && cmd.rd))
		else $error("table read and write in one cycle");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_CHK)
		else $error("accepted item not checked");
`endif

endmodule
